### rtl/core/mjt_pkg.sv
// Shared types, widths and helpers for the joint TLB.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mjt_pkg;

  localparam int TLB_ENTRIES = 32;
  localparam int IDX_W       = $clog2(TLB_ENTRIES);
  localparam int SLOT_W      = 5;
  localparam int SPAN_W      = IDX_W + 1;

  localparam int VPN_W   = 19;
  localparam int ASID_W  = 8;
  localparam int MASK_W  = 12;
  localparam int HALF_W  = 29;
  localparam int TAG_W   = VPN_W + ASID_W + MASK_W + 1;
  localparam int PAGE_W  = 2 * HALF_W;

  // Count >> 1
  localparam int DIVD_W  = 31;

  localparam int CFG_AW  = 3;
  localparam logic [CFG_AW-3:0] REG_WIRED = '0;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WR_IDX  = 2'd1,
    REQ_WR_RAND = 2'd2,
    REQ_PROBE   = 2'd3
  } mjt_req_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } mjt_rd_req_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [TAG_W-1:0]  tag;
    logic [PAGE_W-1:0] page;
  } mjt_wr_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PAGE_W-1:0] page;
  } mjt_rd_data_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [SPAN_W-1:0] divisor;
  } mjt_rem_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mjt_rem_rsp_t;

  // {PFN, C, D, V} sit contiguously in EntryLo bits 29..1
  function automatic logic [HALF_W-1:0] page_half(input logic [31:0] lo);
    page_half = lo[29:1];
  endfunction

  // tag: G | mask | ASID | VPN2
  function automatic logic [TAG_W-1:0] pack_tag(input logic [31:0] hi,
                                                input logic [31:0] lo0,
                                                input logic [31:0] lo1,
                                                input logic [31:0] pm);
    pack_tag = {lo0[0] & lo1[0], pm[24:13], hi[7:0], hi[31:13]};
  endfunction

endpackage

### rtl/core/mjt_if.sv
// Request and result channel interfaces for the joint TLB.
// Depends on mjt_pkg for field widths.
`timescale 1ns / 1ps

interface mjt_req_if import mjt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [SLOT_W-1:0] slot_index;
  logic [31:0]       entry_hi_word;
  logic [31:0]       entry_lo_even;
  logic [31:0]       entry_lo_odd;
  logic [31:0]       page_mask_word;
  logic [31:0]       cycle_count;

  modport source (output valid, req_type, slot_index, entry_hi_word, entry_lo_even,
                  entry_lo_odd, page_mask_word, cycle_count, input ready);
  modport sink   (input valid, req_type, slot_index, entry_hi_word, entry_lo_even,
                  entry_lo_odd, page_mask_word, cycle_count, output ready);
endinterface

interface mjt_rsp_if import mjt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [24:0]       read_page_mask;
  logic [31:0]       read_entry_hi;
  logic [29:0]       read_lo_even;
  logic [29:0]       read_lo_odd;
  logic [SLOT_W-1:0] probe_slot;
  logic              probe_miss;
  logic [SLOT_W-1:0] written_slot;

  modport source (output valid, read_page_mask, read_entry_hi, read_lo_even, read_lo_odd,
                  probe_slot, probe_miss, written_slot, input ready);
  modport sink   (input valid, read_page_mask, read_entry_hi, read_lo_even, read_lo_odd,
                  probe_slot, probe_miss, written_slot, output ready);
endinterface

### rtl/core/mjt_store.sv
// Entry store: tag and page-pair memories, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses mjt_pkg.
`timescale 1ns / 1ps

module mjt_store import mjt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  mjt_wr_req_t  wr,
  input  mjt_rd_req_t  rd,
  output mjt_rd_data_t rd_data
);

  logic [TAG_W-1:0]       tag_mem_r  [TLB_ENTRIES];
  logic [PAGE_W-1:0]      page_mem_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] vld_r;
  logic [TAG_W-1:0]       rd_tag_r;
  logic [PAGE_W-1:0]      rd_page_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tag_mem_r[wr.addr]  <= wr.tag;
      page_mem_r[wr.addr] <= wr.page;
    end
    if (rd.re) begin
      rd_tag_r  <= tag_mem_r[rd.addr];
      rd_page_r <= page_mem_r[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.re) begin
        rd_vld_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_data.tag  = rd_vld_r ? rd_tag_r  : '0;
  assign rd_data.page = rd_vld_r ? rd_page_r : '0;

endmodule

### rtl/core/mjt_rem.sv
// Radix-2 restoring remainder unit, one dividend bit per cycle.
// Gives (Count >> 1) mod span for random replacement. Uses mjt_pkg.
`timescale 1ns / 1ps

module mjt_rem import mjt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  mjt_rem_req_t req,
  output mjt_rem_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVD_W - 1);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [SPAN_W-1:0] div_r;
  logic [SPAN_W-1:0] rem_r;
  logic [SPAN_W-1:0] rem_nxt;
  logic [SPAN_W:0]   part;

  always_comb begin
    part = {rem_r, quo_r[DIVD_W-1]};
    if (part >= {1'b0, div_r}) begin
      rem_nxt = SPAN_W'(part - {1'b0, div_r});
    end else begin
      rem_nxt = part[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[IDX_W-1:0];

endmodule

### rtl/core/mips_joint_tlb_top.sv
// Top level of the 32-entry joint TLB: sequencer, config register, output register.
// Depends on mjt_pkg, mjt_if, mjt_store and mjt_rem.
`timescale 1ns / 1ps

// Channel   Dir   Handshake          Contents
// in_ch     in    valid/ready        request: type, index, EntryHi/Lo0/Lo1, PageMask, Count
// out_ch    out   valid/ready        result: read words, probe slot/miss, written slot
// cfg_*     in    APB, pready high   register 0 at byte 0: wired_entries (5 bits)
//
// Path of each request, from transfer in to result ready in the output register:
//   indexed write straight to FIN, read via READ, probe via PROBE (one tag read per
//   cycle from the single read port, stops at the first hit), random write via RAND
//   (31 steps of the bit-serial remainder unit); a new transfer is taken only in IDLE.
// Reset clears the FSM, the wired register and the per-entry valid bits, so
// every entry reads as zero until written; no clearing pass is needed.
// A new request is taken while a result still waits in the output register;
// that request then holds in its last state until the result is transferred.

module mips_joint_tlb_top import mjt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mjt_req_if.sink           in_ch,
  mjt_rsp_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_RAND  = 5'b01000,
    ST_FIN   = 5'b10000
  } mjt_state_t;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TLB_ENTRIES - 1);
  localparam logic [SLOT_W-1:0] WIRED_MAX = SLOT_W'(TLB_ENTRIES - 1);
  localparam int PM_SHIFT = 13;
  localparam int HI_GAP   = 32 - VPN_W - ASID_W;

  mjt_state_t state_r, state_nxt;

  // config
  logic [SLOT_W-1:0] wired_r;
  logic [IDX_W-1:0]  w_clamp;
  logic [SPAN_W-1:0] span;
  logic              cfg_wr;

  // request context
  mjt_req_t          req_r;
  logic [TAG_W-1:0]  wtag_r;
  logic [PAGE_W-1:0] wpage_r;
  logic [VPN_W-1:0]  qvpn_r;
  logic [ASID_W-1:0] qasid_r;
  logic [SLOT_W-1:0] slot_in_r;
  logic [IDX_W-1:0]  scan_r;

  // pending result
  logic [24:0]       res_pm_r;
  logic [31:0]       res_hi_r;
  logic [29:0]       res_lo0_r;
  logic [29:0]       res_lo1_r;
  logic [SLOT_W-1:0] res_pslot_r;
  logic              res_miss_r;
  logic [SLOT_W-1:0] res_wslot_r;

  // output register
  logic              out_valid_r;
  logic [24:0]       out_pm_r;
  logic [31:0]       out_hi_r;
  logic [29:0]       out_lo0_r;
  logic [29:0]       out_lo1_r;
  logic [SLOT_W-1:0] out_pslot_r;
  logic              out_miss_r;
  logic [SLOT_W-1:0] out_wslot_r;

  logic              in_acc;
  mjt_req_t          in_req;
  logic              out_free;
  logic              fin_go;
  logic              is_write;

  mjt_rd_req_t       rd;
  mjt_wr_req_t       wr;
  mjt_rd_data_t      rd_data;
  mjt_rem_req_t      rem_req;
  mjt_rem_rsp_t      rem_rsp;

  // decoded entry at the read port
  logic [VPN_W-1:0]  e_vpn;
  logic [ASID_W-1:0] e_asid;
  logic [MASK_W-1:0] e_mask;
  logic              e_g;
  logic [VPN_W-1:0]  keep;
  logic              hit;
  logic [IDX_W-1:0]  slot_rand;

  mjt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  mjt_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_AW-1:2] == REG_WIRED);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_WIRED) ?
                      {{(32-SLOT_W){1'b0}}, wired_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wired_r <= '0;
    end else if (cfg_wr) begin
      wired_r <= cfg_pwdata[SLOT_W-1:0];
    end
  end

  // wired stays below the entry count so the random span is never zero
  assign w_clamp = IDX_W'((wired_r > WIRED_MAX) ? WIRED_MAX : wired_r);
  assign span    = SPAN_W'(TLB_ENTRIES) - {1'b0, w_clamp};

  // ---------------------------------------------------------------- handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_req      = mjt_req_t'(in_ch.req_type);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign fin_go      = (state_r == ST_FIN) && out_free;
  assign is_write    = (req_r == REQ_WR_IDX) || (req_r == REQ_WR_RAND);

  // ---------------------------------------------------------------- store ports
  // Read data appears in the cycle after its address; a probe issues entry 0 with the
  // transfer and then scan_r + 1 each cycle while scan_r is being compared.
  always_comb begin
    rd.re   = 1'b0;
    rd.addr = scan_r + 1'b1;
    if (in_acc) begin
      rd.re   = (in_req == REQ_READ) || (in_req == REQ_PROBE);
      rd.addr = (in_req == REQ_PROBE) ? '0 : in_ch.slot_index[IDX_W-1:0];
    end else if (state_r == ST_PROBE) begin
      rd.re = 1'b1;
    end
  end

  // entries are written only at the end of a request, so a following
  // request's reads always see the new contents
  assign wr.we   = fin_go && is_write;
  assign wr.addr = res_wslot_r[IDX_W-1:0];
  assign wr.tag  = wtag_r;
  assign wr.page = wpage_r;

  assign rem_req.start    = in_acc && (in_req == REQ_WR_RAND);
  assign rem_req.dividend = in_ch.cycle_count[31:1];
  assign rem_req.divisor  = span;

  // remainder < span, so the sum stays inside the table
  assign slot_rand = rem_rsp.rem + w_clamp;

  // ---------------------------------------------------------------- match
  assign e_vpn  = rd_data.tag[VPN_W-1:0];
  assign e_asid = rd_data.tag[VPN_W +: ASID_W];
  assign e_mask = rd_data.tag[VPN_W+ASID_W +: MASK_W];
  assign e_g    = rd_data.tag[TAG_W-1];
  assign keep   = ~{{(VPN_W-MASK_W){1'b0}}, e_mask};
  assign hit    = (((e_vpn ^ qvpn_r) & keep) == '0) && (e_g || (e_asid == qasid_r));

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req)
            REQ_READ:    state_nxt = ST_READ;
            REQ_WR_IDX:  state_nxt = ST_FIN;
            REQ_WR_RAND: state_nxt = ST_RAND;
            REQ_PROBE:   state_nxt = ST_PROBE;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_FIN;
      ST_PROBE: begin
        if (hit || (scan_r == LAST_IDX)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_RAND: begin
        if (rem_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        scan_r <= '0;
      end else if ((state_r == ST_PROBE) && !hit && (scan_r != LAST_IDX)) begin
        scan_r <= scan_r + 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r       <= in_req;
      wtag_r      <= pack_tag(in_ch.entry_hi_word, in_ch.entry_lo_even,
                              in_ch.entry_lo_odd, in_ch.page_mask_word);
      wpage_r     <= {page_half(in_ch.entry_lo_odd), page_half(in_ch.entry_lo_even)};
      qvpn_r      <= in_ch.entry_hi_word[31:13];
      qasid_r     <= in_ch.entry_hi_word[7:0];
      slot_in_r   <= in_ch.slot_index;
      res_pm_r    <= '0;
      res_hi_r    <= '0;
      res_lo0_r   <= '0;
      res_lo1_r   <= '0;
      res_pslot_r <= '0;
      res_miss_r  <= 1'b0;
      res_wslot_r <= (in_req == REQ_WR_IDX) ?
                     SLOT_W'(in_ch.slot_index[IDX_W-1:0]) : '0;
    end

    if (state_r == ST_READ) begin
      res_pm_r  <= {e_mask, {PM_SHIFT{1'b0}}};
      res_hi_r  <= {e_vpn, {HI_GAP{1'b0}}, e_asid};
      res_lo0_r <= {rd_data.page[HALF_W-1:0], e_g};
      res_lo1_r <= {rd_data.page[PAGE_W-1:HALF_W], e_g};
    end

    if (state_r == ST_PROBE) begin
      if (hit) begin
        res_pslot_r <= SLOT_W'(scan_r);
      end else if (scan_r == LAST_IDX) begin
        res_pslot_r <= slot_in_r;
        res_miss_r  <= 1'b1;
      end
    end

    if ((state_r == ST_RAND) && rem_rsp.done) begin
      res_wslot_r <= SLOT_W'(slot_rand);
    end

    if (fin_go) begin
      out_pm_r    <= res_pm_r;
      out_hi_r    <= res_hi_r;
      out_lo0_r   <= res_lo0_r;
      out_lo1_r   <= res_lo1_r;
      out_pslot_r <= res_pslot_r;
      out_miss_r  <= res_miss_r;
      out_wslot_r <= res_wslot_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_page_mask = out_pm_r;
  assign out_ch.read_entry_hi  = out_hi_r;
  assign out_ch.read_lo_even   = out_lo0_r;
  assign out_ch.read_lo_odd    = out_lo1_r;
  assign out_ch.probe_slot     = out_pslot_r;
  assign out_ch.probe_miss     = out_miss_r;
  assign out_ch.written_slot   = out_wslot_r;

endmodule

### test/tb_mips_joint_tlb_top.sv
// Self-checking bench for the 32-entry joint TLB: read, write, random replace, probe.
// Depends on mjt_pkg, mjt_if and the mips_joint_tlb_top RTL.
`timescale 1ns / 1ps

module tb_mips_joint_tlb_top;
  import mjt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;   // random write and a probe over the whole table are the slowest requests
  localparam int PRINT_CAP   = 40;

  // One request as the bench sees it
  typedef struct packed {
    mjt_req_t          op;
    logic [SLOT_W-1:0] slot_index;
    logic [31:0]       hi;
    logic [31:0]       lo0;
    logic [31:0]       lo1;
    logic [31:0]       pm;
    logic [31:0]       cnt;
  } tlb_req_t;

  // One result, same widths as the result channel
  typedef struct packed {
    logic [24:0]       page_mask;
    logic [31:0]       entry_hi;
    logic [29:0]       lo_even;
    logic [29:0]       lo_odd;
    logic [SLOT_W-1:0] probe_slot;
    logic              probe_miss;
    logic [SLOT_W-1:0] written_slot;
  } tlb_rsp_t;

  // Shadow copy of one TLB entry
  typedef struct packed {
    logic        glob;
    logic [11:0] mask;
    logic [7:0]  asid;
    logic [18:0] vpn2;
    logic [28:0] even;  // PFN, C, D, V
    logic [28:0] odd;
  } tlb_entry_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  mjt_req_if req_ch ();
  mjt_rsp_if rsp_ch ();

  mips_joint_tlb_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow TLB state and the wired count as the block should hold them
  tlb_entry_t  entries [TLB_ENTRIES];
  logic [4:0]  wired_q;

  tlb_req_t    pending_reqs[$];   // stimulus not yet presented
  tlb_rsp_t    results_due[$];    // predicted results, oldest first
  logic [31:0] known_hi[$];       // recent EntryHi words, used to aim probes at live entries
  tlb_req_t    req_on_bus;

  int sent_count = 0;
  int rsp_count  = 0;
  int n_bad      = 0;
  int n_reads    = 0;
  int n_writes   = 0;
  int n_probes   = 0;
  int n_hits     = 0;
  int n_cfg      = 0;
  int cycles     = 0;

  // No random idling on either side while this window of transfers goes through
  logic steady;
  assign steady = (sent_count >= 180) && (sent_count < 300);

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_bad < PRINT_CAP)
      $display("mismatch at result %0d: %s got 0x%08h want 0x%08h", rsp_count, what, got, want);
    n_bad++;
  endtask

  function automatic tlb_entry_t unpack_words(input tlb_req_t r);
    tlb_entry_t e;
    e.vpn2 = r.hi[31:13];
    e.asid = r.hi[7:0];
    e.mask = r.pm[24:13];
    // global only when both halves say so
    e.glob = r.lo0[0] & r.lo1[0];
    e.even = {r.lo0[29:6], r.lo0[5:3], r.lo0[2], r.lo0[1]};
    e.odd  = {r.lo1[29:6], r.lo1[5:3], r.lo1[2], r.lo1[1]};
    return e;
  endfunction

  // Applies one request to the shadow TLB and returns the result it must produce
  function automatic tlb_rsp_t tlb_apply(input tlb_req_t r);
    tlb_rsp_t    res;
    tlb_entry_t  e;
    int unsigned idx;
    int unsigned w;
    int unsigned span;
    int unsigned slot;
    logic [18:0] keep;
    logic [18:0] qvpn;
    logic [7:0]  qasid;
    bit          found;
    res = '0;
    idx = r.slot_index % TLB_ENTRIES;
    case (r.op)
      REQ_READ: begin
        e = entries[idx[IDX_W-1:0]];
        res.page_mask = {e.mask, 13'b0};
        res.entry_hi  = {e.vpn2, 5'b0, e.asid};
        res.lo_even   = {e.even, e.glob};
        res.lo_odd    = {e.odd, e.glob};
        n_reads++;
      end
      REQ_WR_IDX: begin
        entries[idx[IDX_W-1:0]] = unpack_words(r);
        res.written_slot = idx[SLOT_W-1:0];
        n_writes++;
      end
      REQ_WR_RAND: begin
        w = 32'(wired_q);
        if (w >= TLB_ENTRIES) w = TLB_ENTRIES - 1;
        span = TLB_ENTRIES - w;
        slot = ((r.cnt >> 1) % span) + w;
        entries[slot[IDX_W-1:0]] = unpack_words(r);
        res.written_slot = slot[SLOT_W-1:0];
        n_writes++;
      end
      default: begin
        qvpn  = r.hi[31:13];
        qasid = r.hi[7:0];
        found = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (!found) begin
            keep = ~{7'b0, entries[i[IDX_W-1:0]].mask};
            if (((entries[i[IDX_W-1:0]].vpn2 & keep) == (qvpn & keep)) &&
                (entries[i[IDX_W-1:0]].glob || entries[i[IDX_W-1:0]].asid == qasid)) begin
              found = 1'b1;
              res.probe_slot = i[SLOT_W-1:0];
            end
          end
        end
        if (!found) begin
          res.probe_slot = r.slot_index;
          res.probe_miss = 1'b1;
        end else begin
          n_hits++;
        end
        n_probes++;
      end
    endcase
    return res;
  endfunction

  // Driver: presents queued requests, predicts at the transfer edge.
  // valid gets at most one nonblocking assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid          <= 1'b0;
      req_ch.req_type       <= REQ_READ;
      req_ch.slot_index     <= '0;
      req_ch.entry_hi_word  <= '0;
      req_ch.entry_lo_even  <= '0;
      req_ch.entry_lo_odd   <= '0;
      req_ch.page_mask_word <= '0;
      req_ch.cycle_count    <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        results_due.push_back(tlb_apply(req_on_bus));
        sent_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
          req_on_bus = pending_reqs.pop_front();
          req_ch.req_type       <= req_on_bus.op;
          req_ch.slot_index     <= req_on_bus.slot_index;
          req_ch.entry_hi_word  <= req_on_bus.hi;
          req_ch.entry_lo_even  <= req_on_bus.lo0;
          req_ch.entry_lo_odd   <= req_on_bus.lo1;
          req_ch.page_mask_word <= req_on_bus.pm;
          req_ch.cycle_count    <= req_on_bus.cnt;
          req_ch.valid          <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, field-by-field compare against the oldest prediction
  always @(posedge clk) begin
    tlb_rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due", 32'(rsp_ch.written_slot), '0);
        end else begin
          want = results_due.pop_front();
          if (rsp_ch.read_page_mask !== want.page_mask)
            report_mismatch("read_page_mask", 32'(rsp_ch.read_page_mask),
                            32'(want.page_mask));
          if (rsp_ch.read_entry_hi !== want.entry_hi)
            report_mismatch("read_entry_hi", rsp_ch.read_entry_hi, want.entry_hi);
          if (rsp_ch.read_lo_even !== want.lo_even)
            report_mismatch("read_lo_even", 32'(rsp_ch.read_lo_even), 32'(want.lo_even));
          if (rsp_ch.read_lo_odd !== want.lo_odd)
            report_mismatch("read_lo_odd", 32'(rsp_ch.read_lo_odd), 32'(want.lo_odd));
          if (rsp_ch.probe_slot !== want.probe_slot)
            report_mismatch("probe_slot", 32'(rsp_ch.probe_slot), 32'(want.probe_slot));
          if (rsp_ch.probe_miss !== want.probe_miss)
            report_mismatch("probe_miss", 32'(rsp_ch.probe_miss), 32'(want.probe_miss));
          if (rsp_ch.written_slot !== want.written_slot)
            report_mismatch("written_slot", 32'(rsp_ch.written_slot),
                            32'(want.written_slot));
        end
        rsp_count++;
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 24);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, results_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // APB write of the wired count, then a read back of it
  task automatic cfg_write(input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_WIRED, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge; only the low five bits count
    wired_q = value[4:0];
    n_cfg++;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {27'b0, wired_q})
      report_mismatch("wired read back", cfg_prdata, {27'b0, wired_q});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Wait until every request has been sent and answered, then let the block settle
  task automatic drain();
    while (pending_reqs.size() != 0 || req_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic push_req(input mjt_req_t op, input logic [4:0] idx, input logic [31:0] hi,
                          input logic [31:0] lo0, input logic [31:0] lo1,
                          input logic [31:0] pm, input logic [31:0] cnt);
    tlb_req_t r;
    r.op         = op;
    r.slot_index = idx;
    r.hi         = hi;
    r.lo0        = lo0;
    r.lo1        = lo1;
    r.pm         = pm;
    r.cnt        = cnt;
    if (op == REQ_WR_IDX || op == REQ_WR_RAND) begin
      known_hi.push_back(hi);
      if (known_hi.size() > 16) void'(known_hi.pop_front());
    end
    pending_reqs.push_back(r);
  endtask

  // Random mix. Half the tags come from a small VPN/ASID space so probes collide,
  // and most probes reuse a recently written EntryHi, sometimes with bit 0 or 13 flipped.
  task automatic queue_random(input int n);
    mjt_req_t    op;
    logic [31:0] hi;
    logic [31:0] lo0;
    logic [31:0] lo1;
    logic [31:0] pm;
    int          pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 25)      op = REQ_READ;
      else if (pick < 50) op = REQ_WR_IDX;
      else if (pick < 65) op = REQ_WR_RAND;
      else                op = REQ_PROBE;
      lo0 = $urandom();
      lo1 = $urandom();
      if ($urandom_range(3) == 0) begin
        lo0[0] = 1'b1;
        lo1[0] = 1'b1;
      end
      case ($urandom_range(2))
        0:       pm = '0;
        1:       pm = $urandom();
        default: pm = ((32'h1 << $urandom_range(12)) - 1) << 13;
      endcase
      if ($urandom_range(1) == 0)
        hi = $urandom();
      else
        hi = ($urandom_range(15) << 13) | $urandom_range(3);
      if (op == REQ_PROBE && known_hi.size() != 0 && $urandom_range(9) < 6) begin
        hi = known_hi[$urandom_range(known_hi.size() - 1)];
        if ($urandom_range(3) == 0) hi[0]  = ~hi[0];
        if ($urandom_range(3) == 0) hi[13] = ~hi[13];
      end
      push_req(op, 5'($urandom_range(31)), hi, lo0, lo1, pm, $urandom());
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    wired_q             = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) entries[i[IDX_W-1:0]] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(32'h0);

    // Directed: cleared store, all-ones words, global needs both G bits,
    // random slot at Count extremes, masked probe, probe miss echoes the index.
    push_req(REQ_READ,    5'd0,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_READ,    5'd31, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd9,  32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd17, 32'h0000_00FF, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_WR_IDX,  5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_READ,    5'd31, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd3,  32'hFFFF_E0AB, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_WR_IDX,  5'd0,  32'h8000_2042, 32'h3FFF_FFC1, 32'h0000_003E,
             32'h0000_0000, 32'h0);
    push_req(REQ_READ,    5'd0,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd1,  32'h8000_2042, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd5,  32'h8000_2043, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_WR_IDX,  5'd12, 32'h0123_4567, 32'hC000_002A, 32'h3FFF_FFFF,
             32'hFE00_1FFF, 32'h0);
    push_req(REQ_READ,    5'd12, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_WR_IDX,  5'd7,  32'h0020_0011, 32'h0000_0007, 32'h0000_0001,
             32'h0000_6000, 32'h0);
    push_req(REQ_PROBE,   5'd2,  32'h0020_6011, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd2,  32'h0020_6012, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_WR_RAND, 5'd4,  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
             32'h01FF_E000, 32'h0000_0000);
    push_req(REQ_WR_RAND, 5'd4,  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
             32'h0155_4000, 32'hFFFF_FFFF);
    push_req(REQ_WR_RAND, 5'd4,  32'h0000_2001, 32'h0000_0001, 32'h0000_0001,
             32'h0, 32'h0000_0003);
    push_req(REQ_READ,    5'd31, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_READ,    5'd1,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd30, 32'hF000_2099, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_WR_IDX,  5'd31, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(REQ_PROBE,   5'd30, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();

    // Wired at the top: every random write lands in the last entry.
    // Upper register bits set to show they are ignored.
    cfg_write(32'hFFFF_FFFF);
    queue_random(130);
    drain();

    cfg_write($urandom_range(30, 1));
    queue_random(140);
    drain();

    cfg_write(32'hA5A5_A5A0);
    queue_random(140);
    drain();

    cfg_write(32'h1);
    queue_random(140);
    drain();

    $display("ran %0d requests: %0d reads, %0d writes, %0d probes (%0d hits, %0d misses)",
             sent_count, n_reads, n_writes, n_probes, n_hits, n_probes - n_hits);
    $display("%0d wired settings, %0d results checked, %0d mismatches",
             n_cfg, rsp_count, n_bad);
    if (n_bad == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
